@@ rtl/hrf_pkg.sv @@
// Package for the HTTP response framer: shared types, codes and character tables.
// Used by hrf_parser, hrf_out_queue and http_response_framer_core; no dependencies.
`timescale 1ns / 1ps

package hrf_pkg;

    typedef enum logic [2:0] {
        PH_VERSION = 3'd0,
        PH_CODE    = 3'd1,
        PH_REST    = 3'd2,
        PH_HEADER  = 3'd3,
        PH_SKIP    = 3'd4,
        PH_BODY    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        NS_IDLE   = 3'd0,
        NS_BLANK  = 3'd1,
        NS_MINUS  = 3'd2,
        NS_PLUS   = 3'd3,
        NS_ZERO   = 3'd4,
        NS_ZEROX  = 3'd5,
        NS_DIGITS = 3'd6,
        NS_TRAIL  = 3'd7
    } num_state_t;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2
    } base_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_STATUS    = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_NOSPACE   = 3'd4;

    localparam logic [4:0]  NAME_LEN    = 5'd15;
    localparam logic [31:0] MAG_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] MAG_NEG_MAX = 32'h8000_0000;
    localparam logic [31:0] MAG_CAP     = 32'h8000_0001;
    localparam logic [31:0] BODY_MAX    = 32'hFFFF_FFFF;
    localparam logic [30:0] CAP_RESET   = 31'd4096;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [4:0] DIGIT_NONE = 5'd16;

    // One word per result-producing item: an optional payload byte, then an optional status.
    typedef struct packed {
        logic        pay_valid;
        logic [7:0]  pay_byte;
        logic        stat_valid;
        logic [2:0]  status;
        logic [63:0] rv;
    } result_t;

    typedef struct packed {
        logic       ready;
    } queue_status_t;

    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            4'd14:   ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] code_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = "2";
            2'd1:    ch = "0";
            2'd2:    ch = "0";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (c inside {["0":"9"]})
            d = 5'(c - 8'h30);
        else if (c inside {["a":"f"]})
            d = 5'(c - 8'h61) + 5'd10;
        else if (c inside {["A":"F"]})
            d = 5'(c - 8'h41) + 5'd10;
        return d;
    endfunction

    function automatic logic [4:0] radix_of(input base_t b);
        logic [4:0] r;
        case (b)
            BASE_OCT: r = 5'd8;
            BASE_HEX: r = 5'd16;
            default:  r = 5'd10;
        endcase
        return r;
    endfunction

    // Multiplies by the radix with shifts and saturates just above the negative limit.
    function automatic logic [31:0] accumulate(input logic [31:0] val, input base_t b,
                                               input logic [4:0] d);
        logic [36:0] v;
        case (b)
            BASE_OCT: v = {2'b00, val, 3'b000} + {32'd0, d};
            BASE_HEX: v = {1'b0, val, 4'b0000} + {32'd0, d};
            default:  v = {2'b00, val, 3'b000} + {4'b0000, val, 1'b0} + {32'd0, d};
        endcase
        return (v > {5'd0, MAG_NEG_MAX}) ? MAG_CAP : v[31:0];
    endfunction

endpackage

@@ rtl/hrf_parser.sv @@
// Per-byte parse state of the framer and the results one byte causes.
// Depends on hrf_pkg.
`timescale 1ns / 1ps

module hrf_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       in_byte,
    input  logic             in_end,
    input  logic [30:0]      capacity,
    output hrf_pkg::result_t result
);

    hrf_pkg::phase_t     phase_reg, phase_upd, phase_next;
    logic [2:0]          tok_cnt_reg, tok_cnt_upd, tok_cnt_next;
    logic                match_ok_reg, match_ok_upd, match_ok_next;
    logic [4:0]          line_pos_reg, line_pos_upd, line_pos_next;
    logic                name_match_reg, name_match_upd, name_match_next;
    hrf_pkg::num_state_t num_reg, num_upd, num_next;
    hrf_pkg::base_t      base_reg, base_upd, base_next;
    logic [31:0]         len_reg, len_upd, len_next;
    logic                known_reg, known_upd, known_next;
    logic                neg_reg, neg_upd, neg_next;
    logic [31:0]         body_cnt_reg, body_cnt_upd, body_cnt_next;
    logic [63:0]         value_reg, value_upd, value_next;
    logic [2:0]          err_reg, err_upd, err_next;

    logic [7:0]  lc;
    logic [4:0]  dig;
    logic [31:0] cap_ext;
    logic        allowed;
    logic [2:0]  final_st;

    assign cap_ext = {1'b0, capacity};
    assign dig     = hrf_pkg::digit_of(in_byte);
    assign lc      = (in_byte inside {["A":"Z"]}) ? in_byte + 8'd32 : in_byte;

    always_comb
    begin
        phase_upd      = phase_reg;
        tok_cnt_upd    = tok_cnt_reg;
        match_ok_upd   = match_ok_reg;
        line_pos_upd   = line_pos_reg;
        name_match_upd = name_match_reg;
        num_upd        = num_reg;
        base_upd       = base_reg;
        len_upd        = len_reg;
        known_upd      = known_reg;
        neg_upd        = neg_reg;
        body_cnt_upd   = body_cnt_reg;
        value_upd      = value_reg;
        err_upd        = err_reg;
        if (step && err_reg == hrf_pkg::ST_OK)
        begin
            case (phase_reg)
                hrf_pkg::PH_VERSION:
                begin
                    if (in_byte == hrf_pkg::CH_SPACE)
                        phase_upd = hrf_pkg::PH_CODE;
                    else if (in_byte == hrf_pkg::CH_CR)
                        err_upd = hrf_pkg::ST_MALFORMED;
                end
                hrf_pkg::PH_CODE:
                begin
                    if (in_byte == hrf_pkg::CH_SPACE || in_byte == hrf_pkg::CH_CR)
                    begin
                        if (!(match_ok_reg && tok_cnt_reg == 3'd3))
                            err_upd = hrf_pkg::ST_STATUS;
                        phase_upd = (in_byte == hrf_pkg::CH_SPACE) ? hrf_pkg::PH_REST
                                                                   : hrf_pkg::PH_HEADER;
                        line_pos_upd   = 5'd0;
                        name_match_upd = 1'b1;
                        num_upd        = hrf_pkg::NS_IDLE;
                    end
                    else
                    begin
                        if (tok_cnt_reg >= 3'd3 ||
                            in_byte != hrf_pkg::code_char(tok_cnt_reg[1:0]))
                            match_ok_upd = 1'b0;
                        if (tok_cnt_reg < 3'd4)
                            tok_cnt_upd = tok_cnt_reg + 3'd1;
                    end
                end
                hrf_pkg::PH_REST:
                begin
                    if (in_byte == hrf_pkg::CH_CR)
                    begin
                        phase_upd      = hrf_pkg::PH_HEADER;
                        line_pos_upd   = 5'd0;
                        name_match_upd = 1'b1;
                        num_upd        = hrf_pkg::NS_IDLE;
                    end
                end
                hrf_pkg::PH_HEADER:
                begin
                    if (in_byte == hrf_pkg::CH_CR)
                    begin
                        if (line_pos_reg <= 5'd1)
                            phase_upd = hrf_pkg::PH_SKIP;
                        else
                        begin
                            case (num_reg)
                                hrf_pkg::NS_IDLE:
                                begin
                                end
                                hrf_pkg::NS_ZERO, hrf_pkg::NS_DIGITS, hrf_pkg::NS_TRAIL:
                                begin
                                    if (len_reg > (neg_reg ? hrf_pkg::MAG_NEG_MAX
                                                           : hrf_pkg::MAG_POS_MAX))
                                        err_upd = hrf_pkg::ST_MALFORMED;
                                    else
                                    begin
                                        known_upd = 1'b1;
                                        if (len_reg == 32'd0)
                                            neg_upd = 1'b0;
                                    end
                                end
                                default: err_upd = hrf_pkg::ST_MALFORMED;
                            endcase
                        end
                        line_pos_upd   = 5'd0;
                        name_match_upd = 1'b1;
                        num_upd        = hrf_pkg::NS_IDLE;
                    end
                    else
                    begin
                        if (line_pos_reg >= 5'd1 && line_pos_reg <= hrf_pkg::NAME_LEN)
                        begin
                            if (name_match_reg &&
                                lc == hrf_pkg::name_char(4'(line_pos_reg - 5'd1)))
                            begin
                                if (line_pos_reg == hrf_pkg::NAME_LEN)
                                begin
                                    num_upd  = hrf_pkg::NS_BLANK;
                                    base_upd = hrf_pkg::BASE_DEC;
                                    len_upd  = 32'd0;
                                    neg_upd  = 1'b0;
                                end
                            end
                            else
                                name_match_upd = 1'b0;
                        end
                        else if (line_pos_reg > hrf_pkg::NAME_LEN &&
                                 num_reg != hrf_pkg::NS_IDLE)
                        begin
                            case (num_reg)
                                hrf_pkg::NS_BLANK, hrf_pkg::NS_MINUS, hrf_pkg::NS_PLUS:
                                begin
                                    if (num_reg == hrf_pkg::NS_BLANK &&
                                        (in_byte == hrf_pkg::CH_SPACE ||
                                         in_byte == hrf_pkg::CH_TAB))
                                    begin
                                    end
                                    else if (num_reg == hrf_pkg::NS_BLANK &&
                                             in_byte == hrf_pkg::CH_MINUS)
                                    begin
                                        num_upd = hrf_pkg::NS_MINUS;
                                        neg_upd = 1'b1;
                                    end
                                    else if (num_reg != hrf_pkg::NS_PLUS &&
                                             in_byte == hrf_pkg::CH_PLUS)
                                        num_upd = hrf_pkg::NS_PLUS;
                                    else if (in_byte == hrf_pkg::CH_ZERO)
                                    begin
                                        num_upd = hrf_pkg::NS_ZERO;
                                        len_upd = 32'd0;
                                    end
                                    else if (in_byte inside {["1":"9"]})
                                    begin
                                        num_upd  = hrf_pkg::NS_DIGITS;
                                        base_upd = hrf_pkg::BASE_DEC;
                                        len_upd  = {27'd0, dig};
                                    end
                                    else
                                    begin
                                        err_upd = hrf_pkg::ST_MALFORMED;
                                        num_upd = hrf_pkg::NS_IDLE;
                                    end
                                end
                                hrf_pkg::NS_ZERO:
                                begin
                                    if (in_byte == "x" || in_byte == "X")
                                        num_upd = hrf_pkg::NS_ZEROX;
                                    else if (in_byte == hrf_pkg::CH_LF)
                                        num_upd = hrf_pkg::NS_TRAIL;
                                    else if (dig < 5'd8)
                                    begin
                                        num_upd  = hrf_pkg::NS_DIGITS;
                                        base_upd = hrf_pkg::BASE_OCT;
                                        len_upd  = hrf_pkg::accumulate(len_reg,
                                                                       hrf_pkg::BASE_OCT, dig);
                                    end
                                    else
                                    begin
                                        err_upd = hrf_pkg::ST_MALFORMED;
                                        num_upd = hrf_pkg::NS_IDLE;
                                    end
                                end
                                hrf_pkg::NS_ZEROX:
                                begin
                                    if (dig < 5'd16)
                                    begin
                                        num_upd  = hrf_pkg::NS_DIGITS;
                                        base_upd = hrf_pkg::BASE_HEX;
                                        len_upd  = {27'd0, dig};
                                    end
                                    else
                                    begin
                                        err_upd = hrf_pkg::ST_MALFORMED;
                                        num_upd = hrf_pkg::NS_IDLE;
                                    end
                                end
                                hrf_pkg::NS_DIGITS:
                                begin
                                    if (dig < hrf_pkg::radix_of(base_reg))
                                        len_upd = hrf_pkg::accumulate(len_reg, base_reg, dig);
                                    else if (in_byte == hrf_pkg::CH_LF)
                                        num_upd = hrf_pkg::NS_TRAIL;
                                    else
                                    begin
                                        err_upd = hrf_pkg::ST_MALFORMED;
                                        num_upd = hrf_pkg::NS_IDLE;
                                    end
                                end
                                default:
                                begin
                                    err_upd = hrf_pkg::ST_MALFORMED;
                                    num_upd = hrf_pkg::NS_IDLE;
                                end
                            endcase
                        end
                        if (line_pos_reg <= hrf_pkg::NAME_LEN)
                            line_pos_upd = line_pos_reg + 5'd1;
                    end
                end
                hrf_pkg::PH_SKIP:
                    phase_upd = hrf_pkg::PH_BODY;
                default:
                begin
                    if (body_cnt_reg < 32'd8)
                        value_upd[{body_cnt_reg[2:0], 3'b000} +: 8] =
                            value_reg[{body_cnt_reg[2:0], 3'b000} +: 8] | in_byte;
                    if (body_cnt_reg != hrf_pkg::BODY_MAX)
                        body_cnt_upd = body_cnt_reg + 32'd1;
                end
            endcase
        end
    end

    always_comb
    begin
        allowed = err_reg == hrf_pkg::ST_OK && known_reg && !neg_reg &&
                  len_reg >= 32'd8 && (len_reg - 32'd8) <= cap_ext;
        final_st = hrf_pkg::ST_MALFORMED;
        if (err_upd != hrf_pkg::ST_OK)
            final_st = err_upd;
        else
        begin
            case (phase_upd)
                hrf_pkg::PH_CODE:
                    final_st = (match_ok_upd && tok_cnt_upd == 3'd3) ? hrf_pkg::ST_MALFORMED
                                                                     : hrf_pkg::ST_STATUS;
                hrf_pkg::PH_SKIP, hrf_pkg::PH_BODY:
                begin
                    if (!known_upd)
                        final_st = hrf_pkg::ST_MALFORMED;
                    else if (neg_upd)
                        final_st = hrf_pkg::ST_SHORT;
                    else if (phase_upd == hrf_pkg::PH_SKIP || len_upd > body_cnt_upd)
                        final_st = hrf_pkg::ST_MALFORMED;
                    else if (len_upd < 32'd8)
                        final_st = hrf_pkg::ST_SHORT;
                    else if ((len_upd - 32'd8) > cap_ext)
                        final_st = hrf_pkg::ST_NOSPACE;
                    else
                        final_st = hrf_pkg::ST_OK;
                end
                default: final_st = hrf_pkg::ST_MALFORMED;
            endcase
        end
        result.pay_valid  = step && err_reg == hrf_pkg::ST_OK &&
                            phase_reg == hrf_pkg::PH_BODY && body_cnt_reg >= 32'd8 &&
                            allowed && body_cnt_reg < len_reg;
        result.pay_byte   = in_byte;
        result.stat_valid = step && in_end;
        result.status     = final_st;
        result.rv         = (final_st == hrf_pkg::ST_OK) ? value_upd : 64'd0;
    end

    always_comb
    begin
        if (step && in_end)
        begin
            phase_next      = hrf_pkg::PH_VERSION;
            tok_cnt_next    = 3'd0;
            match_ok_next   = 1'b1;
            line_pos_next   = 5'd0;
            name_match_next = 1'b1;
            num_next        = hrf_pkg::NS_IDLE;
            base_next       = hrf_pkg::BASE_DEC;
            len_next        = 32'd0;
            known_next      = 1'b0;
            neg_next        = 1'b0;
            body_cnt_next   = 32'd0;
            value_next      = 64'd0;
            err_next        = hrf_pkg::ST_OK;
        end
        else
        begin
            phase_next      = phase_upd;
            tok_cnt_next    = tok_cnt_upd;
            match_ok_next   = match_ok_upd;
            line_pos_next   = line_pos_upd;
            name_match_next = name_match_upd;
            num_next        = num_upd;
            base_next       = base_upd;
            len_next        = len_upd;
            known_next      = known_upd;
            neg_next        = neg_upd;
            body_cnt_next   = body_cnt_upd;
            value_next      = value_upd;
            err_next        = err_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= hrf_pkg::PH_VERSION;
            tok_cnt_reg    <= 3'd0;
            match_ok_reg   <= 1'b1;
            line_pos_reg   <= 5'd0;
            name_match_reg <= 1'b1;
            num_reg        <= hrf_pkg::NS_IDLE;
            base_reg       <= hrf_pkg::BASE_DEC;
            len_reg        <= 32'd0;
            known_reg      <= 1'b0;
            neg_reg        <= 1'b0;
            body_cnt_reg   <= 32'd0;
            value_reg      <= 64'd0;
            err_reg        <= hrf_pkg::ST_OK;
        end
        else
        begin
            phase_reg      <= phase_next;
            tok_cnt_reg    <= tok_cnt_next;
            match_ok_reg   <= match_ok_next;
            line_pos_reg   <= line_pos_next;
            name_match_reg <= name_match_next;
            num_reg        <= num_next;
            base_reg       <= base_next;
            len_reg        <= len_next;
            known_reg      <= known_next;
            neg_reg        <= neg_next;
            body_cnt_reg   <= body_cnt_next;
            value_reg      <= value_next;
            err_reg        <= err_next;
        end
    end

endmodule

@@ rtl/hrf_out_queue.sv @@
// Two-entry result queue that sends, per entry, its payload word if any and then its status word if any.
// Depends on hrf_pkg.
`timescale 1ns / 1ps

module hrf_out_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hrf_pkg::result_t       push_data,
    output hrf_pkg::queue_status_t qstat,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   result_kind,
    output logic [7:0]             payload_byte,
    output logic [2:0]             resp_status,
    output logic signed [63:0]     resp_value,
    output logic                   last_of_item
);

    hrf_pkg::result_t entry_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       sent_reg, sent_next;

    hrf_pkg::result_t head;
    logic push, pop, fire, emit_pay;

    assign head     = entry_reg[rd_ptr_reg];
    assign push     = (push_data.pay_valid || push_data.stat_valid) && count_reg != 2'd2;
    assign emit_pay = head.pay_valid && !sent_reg;
    assign fire     = out_valid && !out_stall;
    assign pop      = fire && !(emit_pay && head.stat_valid);

    assign qstat.ready = count_reg != 2'd2;

    assign out_valid    = count_reg != 2'd0;
    assign result_kind  = !emit_pay;
    assign payload_byte = emit_pay ? head.pay_byte : 8'd0;
    assign resp_status  = emit_pay ? hrf_pkg::ST_OK : head.status;
    assign resp_value   = emit_pay ? 64'sd0 : $signed(head.rv);
    assign last_of_item = !emit_pay || !head.stat_valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        if (pop)
            sent_next = 1'b0;
        else if (fire)
            sent_next = 1'b1;
        else
            sent_next = sent_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            sent_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            sent_reg   <= sent_next;
        end
    end

endmodule

@@ rtl/http_response_framer_core.sv @@
// Top level of the HTTP response framer: input register, parser and result queue.
// Depends on hrf_pkg, hrf_parser and hrf_out_queue.
`timescale 1ns / 1ps

// The framer takes one response byte per cycle while in_stall is low and passes it
// through a single registered parse step: an accepted byte is held in the input
// register, parsed once the result queue has room, and its result words are written
// into the queue and offered from there. Bytes are accepted every cycle while the
// two-entry result queue has room. The queue sends one word per cycle while the
// output is not stalled; it fills when the output side stalls, and because a
// response end that carries a payload word as well as its status holds the queue
// head for both words, a result-producing byte close behind it can hold the input.
// Body bytes after the eight-byte return value and within a valid declared length
// that fits the capacity come out as payload words as they arrive, and the byte
// marked end_of_data adds a final status word. The consumer must discard the
// payload of a response whose status is not ok. The capacity register is written
// through cfg_write_en and should stay steady during a response.
module http_response_framer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [30:0]        cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               end_of_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               result_kind,
    output logic [7:0]         payload_byte,
    output logic [2:0]         resp_status,
    output logic signed [63:0] resp_value,
    output logic               last_of_item
);

    logic [30:0] capacity_reg;
    logic        in_full_reg, in_full_next;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;
    logic        accept, advance;

    hrf_pkg::result_t       result;
    hrf_pkg::queue_status_t qstat;

    assign advance  = in_full_reg && qstat.ready;
    assign in_stall = in_full_reg && !qstat.ready;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            in_full_next = 1'b1;
        else if (advance)
            in_full_next = 1'b0;
        else
            in_full_next = in_full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            capacity_reg <= hrf_pkg::CAP_RESET;
        end
        else
        begin
            in_full_reg <= in_full_next;
            if (cfg_write_en)
                capacity_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= data_byte;
            in_end_reg  <= end_of_data;
        end
    end

    hrf_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .in_byte  (in_byte_reg),
        .in_end   (in_end_reg),
        .capacity (capacity_reg),
        .result   (result)
    );

    hrf_out_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_data    (result),
        .qstat        (qstat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .payload_byte (payload_byte),
        .resp_status  (resp_status),
        .resp_value   (resp_value),
        .last_of_item (last_of_item)
    );

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind |-> last_of_item)
        else $error("status word without last_of_item");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_kind |-> resp_status == hrf_pkg::ST_OK && resp_value == 64'sd0)
        else $error("payload word carries status fields");

    a_error_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind && resp_status != hrf_pkg::ST_OK |-> resp_value == 64'sd0)
        else $error("failed status carries a return value");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> resp_status <= hrf_pkg::ST_NOSPACE)
        else $error("status code out of range");

endmodule
